/* design/dq_pkg.sv */
// dq_pkg: shared sizes, codes, types and ring index helpers for the deque
// used by dq_ctrl, dq_dp and double_ended_queue; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int DEPTH      = 32;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int REQ_W      = 3;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ELEM_WIDTH-1:0] elem_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ_OUT   = 3'd4,
    REQ_CLEAR      = 3'd5
  } dq_req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_CLEAR,
    OP_READ_FIRST,
    OP_READ_NEXT
  } dq_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_STREAM
  } dq_state_t;

  // controller -> datapath
  typedef struct packed {
    dq_op_t     op;
    logic       emit_direct;
    dq_status_t emit_status;
    logic       load_mem;
    logic       mem_last;
  } dq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
    logic read_done;
  } dq_stat_t;

  // idx + off around the ring, both below DEPTH
  function automatic idx_t ring_add(input idx_t idx, input idx_t off);
    logic [IDX_W:0] sum;
    sum = {1'b0, idx} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic idx_t ring_next(input idx_t idx);
    return ring_add(idx, IDX_W'(1));
  endfunction

  function automatic idx_t ring_prev(input idx_t idx);
    return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

/* design/dq_ctrl.sv */
// dq_ctrl: request sequencer for the deque, decodes requests and paces read-outs
// depends on dq_pkg; drives dq_dp through dq_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire dq_req_t  in_req,
  output logic          in_ready,
  input  wire dq_stat_t stat,
  output dq_cmd_t       cmd
);

  dq_state_t state_r, state_nxt;
  logic      pend_r, pend_nxt;
  logic      load, issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    pend_nxt        = pend_r;
    in_ready        = 1'b0;
    cmd.op          = OP_NONE;
    cmd.emit_direct = 1'b0;
    cmd.emit_status = ST_OK;
    cmd.load_mem    = 1'b0;
    cmd.mem_last    = 1'b0;
    load            = 1'b0;
    issue           = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          unique case (in_req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              cmd.emit_direct = 1'b1;
              if (stat.full) begin
                cmd.emit_status = ST_FULL;
              end else begin
                cmd.op = (in_req == REQ_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (stat.empty) begin
                cmd.emit_direct = 1'b1;
                cmd.emit_status = ST_EMPTY;
              end else begin
                cmd.op    = (in_req == REQ_POP_FRONT) ? OP_POP_FRONT : OP_POP_BACK;
                state_nxt = S_POP;
              end
            end
            REQ_READ_OUT: begin
              if (stat.empty) begin
                cmd.emit_direct = 1'b1;
                cmd.emit_status = ST_EMPTY;
              end else begin
                cmd.op    = OP_READ_FIRST;
                pend_nxt  = 1'b1;
                state_nxt = S_STREAM;
              end
            end
            REQ_CLEAR: begin
              cmd.op          = OP_CLEAR;
              cmd.emit_direct = 1'b1;
            end
            default: begin
              cmd.emit_direct = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        // output slot is free: it was free when the pop was taken
        cmd.load_mem = 1'b1;
        cmd.mem_last = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_STREAM: begin
        load         = pend_r && stat.out_free;
        issue        = !stat.read_done && (!pend_r || load);
        cmd.load_mem = load;
        cmd.mem_last = stat.read_done;
        if (issue) begin
          cmd.op   = OP_READ_NEXT;
          pend_nxt = 1'b1;
        end else if (load) begin
          pend_nxt = 1'b0;
        end
        if (load && stat.read_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/dq_dp.sv */
// dq_dp: deque datapath with slot memory, ring pointers, read-out counter and result register
// depends on dq_pkg; commanded by dq_ctrl
`timescale 1ns / 1ps
`default_nettype none

module dq_dp
  import dq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire dq_cmd_t cmd,
  input  wire elem_t   in_elem,
  input  wire logic    in_ftb,
  output dq_stat_t     stat,
  input  wire logic    out_ready,
  output logic         out_valid,
  output elem_t        out_elem,
  output dq_status_t   out_status,
  output cnt_t         out_count,
  output logic         out_empty,
  output logic         out_last
);

  elem_t      mem [DEPTH];
  elem_t      rd_data_r;

  idx_t       front_r, front_nxt;
  cnt_t       count_r, count_nxt;
  cnt_t       k_r, k_nxt;
  logic       ftb_r, ftb_nxt;

  logic       out_valid_r;
  elem_t      elem_r;
  dq_status_t status_r;
  cnt_t       cnt_out_r;
  logic       last_r;

  idx_t       cnt_m1;
  idx_t       pos_k;
  idx_t       position;
  logic       ftb_sel;
  idx_t       rd_addr;
  idx_t       wr_addr;
  logic       rd_en;
  logic       wr_en;

  assign cnt_m1   = count_r[IDX_W-1:0] - IDX_W'(1);
  assign pos_k    = (cmd.op == OP_READ_FIRST) ? '0 : k_r[IDX_W-1:0];
  assign ftb_sel  = (cmd.op == OP_READ_FIRST) ? in_ftb : ftb_r;
  assign position = ftb_sel ? pos_k : (cnt_m1 - pos_k);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    ftb_nxt   = ftb_r;
    rd_addr   = ring_add(front_r, position);
    wr_addr   = ring_add(front_r, count_r[IDX_W-1:0]);
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    case (cmd.op)
      OP_PUSH_FRONT: begin
        front_nxt = ring_prev(front_r);
        wr_addr   = ring_prev(front_r);
        wr_en     = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end
      OP_PUSH_BACK: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end
      OP_POP_FRONT: begin
        rd_addr   = front_r;
        rd_en     = 1'b1;
        front_nxt = ring_next(front_r);
        count_nxt = count_r - CNT_W'(1);
      end
      OP_POP_BACK: begin
        rd_addr   = ring_add(front_r, cnt_m1);
        rd_en     = 1'b1;
        count_nxt = count_r - CNT_W'(1);
      end
      OP_CLEAR: begin
        front_nxt = '0;
        count_nxt = '0;
      end
      OP_READ_FIRST: begin
        rd_en   = 1'b1;
        k_nxt   = CNT_W'(1);
        ftb_nxt = in_ftb;
      end
      OP_READ_NEXT: begin
        rd_en = 1'b1;
        k_nxt = k_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // slot memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_elem;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      k_r         <= '0;
      ftb_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
      ftb_r   <= ftb_nxt;
      if (cmd.emit_direct || cmd.load_mem) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_direct) begin
      elem_r    <= '0;
      status_r  <= cmd.emit_status;
      cnt_out_r <= count_nxt;
      last_r    <= 1'b1;
    end else if (cmd.load_mem) begin
      elem_r    <= rd_data_r;
      status_r  <= ST_OK;
      cnt_out_r <= count_r;
      last_r    <= cmd.mem_last;
    end
  end

  assign stat.full      = (count_r == CNT_W'(DEPTH));
  assign stat.empty     = (count_r == '0);
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.read_done = (k_r == count_r);

  assign out_valid  = out_valid_r;
  assign out_elem   = elem_r;
  assign out_status = status_r;
  assign out_count  = cnt_out_r;
  assign out_empty  = (cnt_out_r == '0);
  assign out_last   = last_r;

endmodule

`default_nettype wire

/* design/double_ended_queue.sv */
// double_ended_queue: a push, clear or refused request loads its result on acceptance;
// a pop or first read-out beat reads a slot into a register, then loads the result from it
// throughput, while results are not stalled: one request per cycle for pushes and clear;
// a pop blocks new requests until its result loads; a read-out streams one beat per cycle
// reset (rst_n low, synchronous) empties the queue and front index; slot contents are kept
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // element_in[31:0], front_to_back[32], zero pad
  input  wire logic [REQ_W-1:0]      in_tuser,   // req_type[2:0]
  // result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // element_out[31:0], count_now[37:32],
                                                 // is_empty[38], zero pad
  output logic [STAT_W-1:0]          out_tuser,  // status[1:0]
  output logic                       out_tlast   // last beat of this request
);

  dq_cmd_t    cmd;
  dq_stat_t   stat;
  dq_req_t    in_req;
  elem_t      in_elem;
  logic       in_ftb;

  elem_t      out_elem;
  dq_status_t out_status;
  cnt_t       out_count;
  logic       out_empty;

  // unpack the request beat
  assign in_req  = dq_req_t'(in_tuser);
  assign in_elem = in_tdata[ELEM_WIDTH-1:0];
  assign in_ftb  = in_tdata[ELEM_WIDTH];

  // request decode and read-out pacing
  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_req   (in_req),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot ring, pointers and result register
  dq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_elem    (in_elem),
    .in_ftb     (in_ftb),
    .stat       (stat),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_elem   (out_elem),
    .out_status (out_status),
    .out_count  (out_count),
    .out_empty  (out_empty),
    .out_last   (out_tlast)
  );

  // pack the result beat
  assign out_tdata = {(OUT_DATA_W - ELEM_WIDTH - CNT_W - 1)'(0), out_empty, out_count, out_elem};
  assign out_tuser = out_status;

`ifndef NO_ASSERTIONS
  // a refused push only happens on a full queue
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> (out_count == CNT_W'(DEPTH)))
    else $error("full status with queue not full");

  // an empty status only with no stored element, and it ends the request
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY) |-> out_tlast && out_empty)
    else $error("empty status beat not final or queue not empty");

  // refused requests carry no element
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_elem == '0))
    else $error("refused request carries an element");

  // no new request is taken while a result beat stalls
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request accepted while result stalled");
`endif

endmodule

`default_nettype wire

/* verif/dq_checker.sv */
// dq_checker: watches the request and result streams of double_ended_queue,
// keeps its own ring of elements to predict every result beat and compares them
// depends on dq_pkg for sizes, request codes and status codes
`timescale 1ns / 1ps

module dq_checker
  import dq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // element_in[31:0], front_to_back[32], zero pad
  input  logic [REQ_W-1:0]      in_tuser,   // req_type[2:0]
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // element_out[31:0], count_now[37:32], is_empty[38]
  input  logic [STAT_W-1:0]     out_tuser,  // status[1:0]
  input  logic                  out_tlast,
  output int                    errors,
  output int                    waiting,
  output int                    reqs_seen,
  output int                    beats_checked,
  output int                    full_hits,
  output int                    empty_hits
);

  typedef struct {
    elem_t      elem;
    dq_status_t status;
    cnt_t       count;
    logic       empty;
    logic       last;
  } deque_beat_t;

  elem_t       slot_word [DEPTH];
  idx_t        head;
  int unsigned fill;
  deque_beat_t due_q [$];

  int mism;
  int n_req;
  int n_beats;
  int n_full;
  int n_empty;

  function automatic idx_t slot_of(input int unsigned pos);
    return idx_t'((int'(head) + pos) % DEPTH);
  endfunction

  function automatic void queue_beat(input elem_t el, input dq_status_t st, input logic fin);
    deque_beat_t b;
    b.elem   = el;
    b.status = st;
    b.count  = cnt_t'(fill);
    b.empty  = (fill == 0);
    b.last   = fin;
    due_q.push_back(b);
    if (st == ST_FULL) n_full++;
    if (st == ST_EMPTY) n_empty++;
  endfunction

  // predicted effect of one accepted request on the ring
  task automatic apply_request(input logic [REQ_W-1:0] req, input elem_t el, input logic ftb);
    elem_t       got;
    int unsigned pos;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          queue_beat('0, ST_FULL, 1'b1);
        end else begin
          if (req == REQ_PUSH_FRONT) begin
            head = (head == '0) ? idx_t'(DEPTH - 1) : head - idx_t'(1);
            slot_word[head] = el;
          end else begin
            slot_word[slot_of(fill)] = el;
          end
          fill++;
          queue_beat('0, ST_OK, 1'b1);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (fill == 0) begin
          queue_beat('0, ST_EMPTY, 1'b1);
        end else begin
          if (req == REQ_POP_FRONT) begin
            got  = slot_word[head];
            head = slot_of(1);
          end else begin
            got = slot_word[slot_of(fill - 1)];
          end
          fill--;
          queue_beat(got, ST_OK, 1'b1);
        end
      end
      REQ_READ_OUT: begin
        if (fill == 0) begin
          queue_beat('0, ST_EMPTY, 1'b1);
        end else begin
          for (int unsigned k = 0; k < fill; k++) begin
            pos = ftb ? k : fill - 1 - k;
            queue_beat(slot_word[slot_of(pos)], ST_OK, k + 1 == fill);
          end
        end
      end
      REQ_CLEAR: begin
        fill = 0;
        head = '0;
        queue_beat('0, ST_OK, 1'b1);
      end
      default: begin
        // spare codes leave the ring alone
        queue_beat('0, ST_OK, 1'b1);
      end
    endcase
  endtask

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    mism++;
    if (mism <= 50)
      $display("mismatch on result beat %0d: %s got 0x%0h want 0x%0h",
               n_beats, what, got, want);
  endtask

  task automatic check_beat();
    deque_beat_t want;
    elem_t       got_elem;
    cnt_t        got_cnt;
    logic        got_empty;
    got_elem  = out_tdata[ELEM_WIDTH-1:0];
    got_cnt   = out_tdata[ELEM_WIDTH +: CNT_W];
    got_empty = out_tdata[ELEM_WIDTH + CNT_W];
    n_beats++;
    if (due_q.size() == 0) begin
      report("unexpected beat, element_out", got_elem, 0);
    end else begin
      want = due_q.pop_front();
      if (got_elem !== want.elem) report("element_out", got_elem, want.elem);
      if (out_tuser !== want.status) report("status", out_tuser, want.status);
      if (got_cnt !== want.count) report("count_now", got_cnt, want.count);
      if (got_empty !== want.empty) report("is_empty", got_empty, want.empty);
      if (out_tlast !== want.last) report("last", out_tlast, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head = '0;
      fill = 0;
      due_q.delete();
    end else begin
      // results never come out in the cycle their request goes in
      if (out_tvalid && out_tready) check_beat();
      if (in_tvalid && in_tready) begin
        n_req++;
        apply_request(in_tuser, in_tdata[ELEM_WIDTH-1:0], in_tdata[ELEM_WIDTH]);
      end
    end
    errors        <= mism;
    waiting       <= due_q.size();
    reqs_seen     <= n_req;
    beats_checked <= n_beats;
    full_hits     <= n_full;
    empty_hits    <= n_empty;
  end

endmodule

/* verif/tb.sv */
// tb: drives requests into double_ended_queue and back-pressures its results
// checking is done by dq_checker; depends on dq_pkg, dq_checker and the design
`timescale 1ns / 1ps

module tb;
  import dq_pkg::*;

  // spare request codes, the block answers them without touching the ring
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 220;   // pressure phase plus random mix
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int TAIL_CYCLES  = 10;    // quiet tail after everything has drained
  localparam int STALL_LIMIT  = 3000;  // cycles with no beat on either side

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // element_in[31:0], front_to_back[32], zero pad
  logic [REQ_W-1:0]      in_tuser;   // req_type[2:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // element_out[31:0], count_now[37:32], is_empty[38]
  logic [STAT_W-1:0]     out_tuser;  // status[1:0]
  logic                  out_tlast;

  int errors;
  int waiting;
  int reqs_seen;
  int beats_checked;
  int full_hits;
  int empty_hits;

  // handshake between the stimulus and the receiver process
  int   hold_ticket = 0;
  int   hold_served = 0;
  logic no_idle     = 1'b0;

  int items_sent;
  int idle_run;

  double_ended_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  dq_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .errors        (errors),
    .waiting       (waiting),
    .reqs_seen     (reqs_seen),
    .beats_checked (beats_checked),
    .full_hits     (full_hits),
    .empty_hits    (empty_hits)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // idle length: mostly none, sometimes short, rarely a long lull
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // one request beat; valid stays high across back-to-back beats
  task automatic send_req(input logic [REQ_W-1:0] req, input elem_t el, input logic ftb);
    int lull;
    lull = no_idle ? 0 : pick_gap();
    if (lull != 0) begin
      in_tvalid <= 1'b0;
      repeat (lull) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{(IN_DATA_W-ELEM_WIDTH-1){1'b0}}, ftb, el};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  function automatic logic [REQ_W-1:0] any_push();
    return $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
  endfunction

  function automatic logic [REQ_W-1:0] any_pop();
    return $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
  endfunction

  // weighted mix of every request kind, spare codes included
  task automatic random_req();
    int                r;
    logic [REQ_W-1:0]  req;
    r = $urandom_range(0, 99);
    if (r < 44)      req = any_push();
    else if (r < 80) req = any_pop();
    else if (r < 90) req = REQ_READ_OUT;
    else if (r < 95) req = REQ_CLEAR;
    else             req = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
    send_req(req, $urandom(), 1'($urandom_range(0, 1)));
  endtask

  // stop offering and wait until every predicted beat has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  // result side: random back-pressure plus the one-off long hold-off
  initial begin : result_sink
    int lull;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_ticket != hold_served) begin
        hold_served = hold_ticket;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        lull = no_idle ? 0 : pick_gap();
        if (lull != 0) begin
          out_tready <= 1'b0;
          repeat (lull) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog: a run that stops moving on both channels is a failure
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= STALL_LIMIT) begin
      $display("no beat for %0d cycles, %0d results outstanding", idle_run, waiting);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int directed_items;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= REQ_PUSH_FRONT;
    in_tdata   <= '0;
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cases, word extremes, ring wrap on push front, both orders
    send_req(REQ_POP_FRONT, 32'h0000_0000, 1'b0);
    send_req(REQ_POP_BACK,  32'h0000_0000, 1'b0);
    send_req(REQ_READ_OUT,  32'h0000_0000, 1'b1);
    send_req(REQ_READ_OUT,  32'h0000_0000, 1'b0);
    send_req(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0);   // front index wraps below zero
    send_req(REQ_PUSH_BACK,  32'h0000_0000, 1'b1);
    send_req(REQ_PUSH_FRONT, 32'hA5A5_A5A5, 1'b1);
    send_req(REQ_PUSH_BACK,  32'h5A5A_5A5A, 1'b0);
    send_req(REQ_READ_OUT,   32'h0000_0000, 1'b1);
    send_req(REQ_READ_OUT,   32'hFFFF_FFFF, 1'b0);
    send_req(REQ_SPARE_LO,   32'hFFFF_FFFF, 1'b1);
    send_req(REQ_SPARE_HI,   32'h0000_0000, 1'b0);
    send_req(REQ_POP_FRONT,  32'h0000_0000, 1'b0);
    send_req(REQ_POP_BACK,   32'h0000_0000, 1'b0);
    send_req(REQ_POP_FRONT,  32'h0000_0000, 1'b1);
    send_req(REQ_POP_BACK,   32'h0000_0000, 1'b1);
    send_req(REQ_POP_FRONT,  32'h0000_0000, 1'b0);   // empty again
    send_req(REQ_PUSH_BACK,  32'h1234_5678, 1'b0);
    send_req(REQ_CLEAR,      32'hFFFF_FFFF, 1'b1);
    send_req(REQ_POP_BACK,   32'h0000_0000, 1'b0);   // nothing left after clear
    send_req(REQ_READ_OUT,   32'h0000_0000, 1'b1);
    send_req(REQ_PUSH_FRONT, 32'h8000_0001, 1'b0);
    send_req(REQ_POP_BACK,   32'h0000_0000, 1'b0);
    directed_items = items_sent;
    items_sent     = 0;

    // receiver goes quiet while pushes keep coming: the block backs up and
    // the queue runs past full, then full read-outs in both orders
    hold_ticket <= hold_ticket + 1;
    no_idle     <= 1'b1;
    repeat (40) send_req(any_push(), $urandom(), 1'($urandom_range(0, 1)));
    no_idle <= 1'b0;
    send_req(REQ_READ_OUT, $urandom(), 1'b1);
    send_req(REQ_READ_OUT, $urandom(), 1'b0);
    repeat (34) send_req(any_pop(), $urandom(), 1'($urandom_range(0, 1)));
    wait_drained();

    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          // fill burst, often reaching full
          repeat ($urandom_range(8, 36))
            send_req(any_push(), $urandom(), 1'($urandom_range(0, 1)));
          send_req(REQ_READ_OUT, $urandom(), 1'($urandom_range(0, 1)));
        end
        1: begin
          // drain burst, often running into empty
          repeat ($urandom_range(4, 36))
            send_req(any_pop(), $urandom(), 1'($urandom_range(0, 1)));
        end
        2: begin
          // stretch with no idling on either side
          no_idle <= 1'b1;
          repeat ($urandom_range(10, 30)) random_req();
          no_idle <= 1'b0;
        end
        3: begin
          // sender pause until the block has answered everything
          wait_drained();
          random_req();
        end
        default: random_req();
      endcase
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d directed, %0d random), %0d result beats checked",
             reqs_seen, directed_items, items_sent, beats_checked);
    $display("refused pushes on a full queue: %0d, pops or read-outs on an empty one: %0d",
             full_hits, empty_hits);
    if (errors == 0 && waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/dq_pkg.sv
design/dq_ctrl.sv
design/dq_dp.sv
design/double_ended_queue.sv
verif/dq_checker.sv
verif/tb.sv
